// ===== sv/murmur64a_key_hash_core_defines.svh =====
// assertion macros shared by the murmur64a key hash core
`ifndef MURMUR64A_KEY_HASH_CORE_DEFINES_SVH
`define MURMUR64A_KEY_HASH_CORE_DEFINES_SVH

// same-cycle implication, checked on i_clk, off during reset
`define MH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, off during reset
`define MH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mh64_pkg.sv =====
// types, constants and microcode program of the murmur64a key hash core
package mh64_pkg;

    // hash constants
    localparam logic [63:0] MUL_K       = 64'hc6a4a7935bd1e995;
    localparam int          SHIFT_R     = 47;
    localparam logic [31:0] MAX_KEY_LEN = 32'd65535;

    // stream word layout
    localparam int WORD_W = 64;
    localparam int NB_W   = 4;
    localparam int LEN_W  = 16;
    localparam int IN_DATA_W = ((WORD_W + NB_W + LEN_W + 7) / 8) * 8;

    // program size
    localparam int          STEP_W    = 5;
    localparam logic [STEP_W-1:0] S_WSEL    = 5'd5;
    localparam logic [STEP_W-1:0] S_TAIL    = 5'd15;
    localparam logic [STEP_W-1:0] S_HMUL    = 5'd16;
    localparam logic [STEP_W-1:0] S_LAST    = 5'd20;
    localparam logic [STEP_W-1:0] LAST_STEP = 5'd24;

    // operand register load select
    typedef enum logic [2:0] {
        A_NONE, A_LEN, A_WORD, A_PXS, A_HXP, A_HXT, A_HXS
    } t_asel;

    // partial product step of the shared multiplier
    typedef enum logic [1:0] {
        MUL_NONE, MUL_LO, MUL_HI1, MUL_HI2
    } t_mul;

    // running hash load select
    typedef enum logic [1:0] {
        H_NONE, H_SEED, H_PROD
    } t_hsel;

    // jump conditions
    typedef enum logic [2:0] {
        C_NONE, C_NOFIRST, C_EMPTY, C_TAIL, C_ALWAYS
    } t_cond;

    // end-of-item conditions
    typedef enum logic [1:0] {
        F_NONE, F_NOTLAST, F_ALWAYS
    } t_fin;

    // one control word
    typedef struct packed {
        t_asel             asel;
        t_mul              mul;
        t_hsel             hsel;
        t_cond             jc;
        logic [STEP_W-1:0] tgt;
        t_fin              fin;
        logic              emit;
    } t_uword;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic first;
        logic last;
        logic empty;
        logic tail;
        logic out_full;
    } t_stat;

    localparam t_uword UW_NOP = '{A_NONE, MUL_NONE, H_NONE, C_NONE, '0, F_NONE, 1'b0};

    // microcode rom
    function automatic t_uword ucode(input logic [STEP_W-1:0] pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            // seed: h = seed ^ (len * M)
            5'd0:  begin w.asel = A_LEN; w.jc = C_NOFIRST; w.tgt = S_WSEL; end
            5'd1:  w.mul = MUL_LO;
            5'd2:  w.mul = MUL_HI1;
            5'd3:  w.mul = MUL_HI2;
            5'd4:  w.hsel = H_SEED;
            // word class
            5'd5:  begin w.jc = C_EMPTY; w.tgt = S_LAST; end
            5'd6:  begin w.asel = A_WORD; w.jc = C_TAIL; w.tgt = S_TAIL; end
            // k *= M
            5'd7:  w.mul = MUL_LO;
            5'd8:  w.mul = MUL_HI1;
            5'd9:  w.mul = MUL_HI2;
            // k ^= k >> r, k *= M
            5'd10: w.asel = A_PXS;
            5'd11: w.mul = MUL_LO;
            5'd12: w.mul = MUL_HI1;
            5'd13: w.mul = MUL_HI2;
            // h ^= k
            5'd14: begin w.asel = A_HXP; w.jc = C_ALWAYS; w.tgt = S_HMUL; end
            // h ^= tail bytes
            5'd15: w.asel = A_HXT;
            // h *= M
            5'd16: w.mul = MUL_LO;
            5'd17: w.mul = MUL_HI1;
            5'd18: w.mul = MUL_HI2;
            5'd19: w.hsel = H_PROD;
            // avalanche
            5'd20: begin w.asel = A_HXS; w.fin = F_NOTLAST; end
            5'd21: w.mul = MUL_LO;
            5'd22: w.mul = MUL_HI1;
            5'd23: w.mul = MUL_HI2;
            5'd24: begin w.emit = 1'b1; w.fin = F_ALWAYS; end
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

    // byte mask of the valid low bytes
    function automatic logic [WORD_W-1:0] byte_mask(input logic [NB_W-1:0] nb);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W / 8; i++) begin
            m[8*i +: 8] = {8{(NB_W'(i) < nb)}};
        end
        return m;
    endfunction

endpackage

// ===== sv/mh64_useq.sv =====
// microcode sequencer: step counter, rom lookup, jumps and item handshake
`include "murmur64a_key_hash_core_defines.svh"

module mh64_useq
    import mh64_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    output logic   o_start,
    input  t_stat  i_stat,
    output t_uword o_ctrl
);

    logic              r_busy, n_busy;
    logic [STEP_W-1:0] r_pc, n_pc;
    t_uword            uw;
    logic              jump;
    logic              done;
    logic              stall;

    assign o_ready = !r_busy;
    assign o_start = i_valid && !r_busy;

    // rom read and condition decode
    always_comb begin
        uw = r_busy ? ucode(r_pc) : UW_NOP;
        unique case (uw.jc)
            C_NOFIRST: jump = !i_stat.first;
            C_EMPTY:   jump = i_stat.empty;
            C_TAIL:    jump = i_stat.tail;
            C_ALWAYS:  jump = 1'b1;
            default:   jump = 1'b0;
        endcase
        unique case (uw.fin)
            F_NOTLAST: done = !i_stat.last;
            F_ALWAYS:  done = 1'b1;
            default:   done = 1'b0;
        endcase
        stall = uw.emit && i_stat.out_full;
    end

    // control word to the datapath, emit held back while output is full
    always_comb begin
        o_ctrl      = uw;
        o_ctrl.emit = uw.emit && !stall;
    end

    // next step
    always_comb begin
        n_busy = r_busy;
        n_pc   = r_pc;
        if (o_start) begin
            n_busy = 1'b1;
            n_pc   = '0;
        end else if (r_busy && !stall) begin
            if (done) begin
                n_busy = 1'b0;
            end else if (jump) begin
                n_pc = uw.tgt;
            end else begin
                n_pc = r_pc + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
        end
    end

    `MH_ASSERT_NXT(a_start_pc, i_rst_n && o_start, r_busy && (r_pc == '0), "start not at step zero")
    `MH_ASSERT_IMP(a_pc_range, r_busy, r_pc <= LAST_STEP, "step counter past program end")
    `MH_ASSERT_NXT(a_stall_hold, i_rst_n && r_busy && stall, r_busy && $stable(r_pc), "stall lost step")
    `MH_ASSERT_IMP(a_emit_step, o_ctrl.emit, r_busy && (r_pc == LAST_STEP), "emit off final step")

endmodule

// ===== sv/mh64_dpath.sv =====
// datapath: word capture, shared 32x32 multiplier, hash and output registers
module mh64_dpath
    import mh64_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WORD_W-1:0] i_word,
    input  logic [NB_W-1:0]   i_nb,
    input  logic              i_first,
    input  logic              i_last,
    input  logic [LEN_W-1:0]  i_len,
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_data,
    input  t_uword            i_ctrl,
    output t_stat             o_stat,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [WORD_W-1:0] o_data
);

    logic [WORD_W-1:0] r_word;
    logic [NB_W-1:0]   r_nb;
    logic              r_first;
    logic              r_last;
    logic [LEN_W-1:0]  r_len;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_h;
    logic [WORD_W-1:0] r_a;
    logic [WORD_W-1:0] r_p;
    logic              r_ovalid;
    logic [WORD_W-1:0] r_odata;

    logic [31:0]       mx, my;
    logic [63:0]       prod;
    logic [LEN_W-1:0]  len_c;
    logic [NB_W-1:0]   nb_c;

    // input clamps
    assign len_c = ({16'd0, i_len} > MAX_KEY_LEN) ? MAX_KEY_LEN[LEN_W-1:0] : i_len;
    assign nb_c  = (i_nb > NB_W'(8)) ? NB_W'(8) : i_nb;

    // word capture
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_word  <= i_word;
            r_nb    <= nb_c;
            r_first <= i_first;
            r_last  <= i_last;
            r_len   <= len_c;
        end
    end

    // seed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_we) begin
            r_seed <= i_cfg_data;
        end
    end

    // shared partial product: lo*lo, lo*k_hi, hi*k_lo
    always_comb begin
        mx   = (i_ctrl.mul == MUL_HI2) ? r_a[63:32] : r_a[31:0];
        my   = (i_ctrl.mul == MUL_HI1) ? MUL_K[63:32] : MUL_K[31:0];
        prod = 64'(mx) * 64'(my);
    end

    // product accumulator
    always_ff @(posedge i_clk) begin
        case (i_ctrl.mul)
            MUL_LO:  r_p <= prod;
            MUL_HI1,
            MUL_HI2: r_p[63:32] <= r_p[63:32] + prod[31:0];
            default: r_p <= r_p;
        endcase
    end

    // multiplier operand
    always_ff @(posedge i_clk) begin
        case (i_ctrl.asel)
            A_LEN:   r_a <= {{(WORD_W-LEN_W){1'b0}}, r_len};
            A_WORD:  r_a <= r_word;
            A_PXS:   r_a <= r_p ^ (r_p >> SHIFT_R);
            A_HXP:   r_a <= r_h ^ r_p;
            A_HXT:   r_a <= r_h ^ (r_word & byte_mask(r_nb));
            A_HXS:   r_a <= r_h ^ (r_h >> SHIFT_R);
            default: r_a <= r_a;
        endcase
    end

    // running hash
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
        end else begin
            case (i_ctrl.hsel)
                H_SEED:  r_h <= r_seed ^ r_p;
                H_PROD:  r_h <= r_p;
                default: r_h <= r_h;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            r_odata <= r_p ^ (r_p >> SHIFT_R);
        end
    end

    // status to the sequencer
    always_comb begin
        o_stat.first    = r_first;
        o_stat.last     = r_last;
        o_stat.empty    = (r_nb == '0);
        o_stat.tail     = (r_nb != '0) && !r_nb[3];
        o_stat.out_full = r_ovalid && !i_ready;
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

// ===== sv/murmur64a_key_hash_core.sv =====
// a new word is accepted only while the sequencer is idle, after the previous word's steps end
// a 64-bit multiply takes three steps of the one shared 32x32 multiplier
// steps: seed at key start, full word scrambled or tail masked then folded, last avalanched
// the next word is taken while a finished hash waits in the output register
// synchronous active-low reset clears seed, running hash, sequencer and output valid
// top level of the murmur64a key hash core
module murmur64a_key_hash_core
    import mh64_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // key words
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,  // key_word, valid_bytes, key_length, zero pad
    input  logic                 s_axis_tuser,  // first_word
    input  logic                 s_axis_tlast,
    // hash results
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [WORD_W-1:0]    m_axis_tdata,  // hash_value
    // seed write
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [WORD_W-1:0]    i_cfg_data
);

    t_uword ctrl;
    t_stat  stat;
    logic   start;

    assign o_cfg_ready = 1'b1;

    // sequencer
    mh64_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .o_start (start),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // datapath
    mh64_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_word     (s_axis_tdata[WORD_W-1:0]),
        .i_nb       (s_axis_tdata[WORD_W +: NB_W]),
        .i_first    (s_axis_tuser),
        .i_last     (s_axis_tlast),
        .i_len      (s_axis_tdata[WORD_W+NB_W +: LEN_W]),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .i_ctrl     (ctrl),
        .o_stat     (stat),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_data     (m_axis_tdata)
    );

endmodule

// ===== sim/murmur64a_key_hash_core_test.sv =====
// testbench of the murmur64a key hash core, directed and random keys against a hash predictor
`timescale 1ns / 100ps

module murmur64a_key_hash_core_test
    import mh64_pkg::*;
();

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int SETTLE_CYCLES   = 30;
    localparam int IDLE_PCT        = 38;
    localparam int RANDOM_WORDS    = 1730;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic                 s_axis_tuser = 1'b0;
    logic                 s_axis_tlast = 1'b0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [WORD_W-1:0]    m_axis_tdata;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    // predictor state and bookkeeping
    logic [WORD_W-1:0] model_seed = '0;
    logic [WORD_W-1:0] model_hash = '0;
    logic [WORD_W-1:0] pending_hashes[$];
    logic [WORD_W-1:0] want_hash;
    int                mismatch_count = 0;
    int                words_sent = 0;
    int                quiet_cycles = 0;
    bit                no_gaps = 1'b0;

    murmur64a_key_hash_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // multiply, shift-xor, multiply of one full word
    function automatic logic [WORD_W-1:0] scramble_word(input logic [WORD_W-1:0] k);
        logic [WORD_W-1:0] t;
        t = k * MUL_K;
        t = t ^ (t >> SHIFT_R);
        t = t * MUL_K;
        return t;
    endfunction

    // final avalanche of the running hash
    function automatic logic [WORD_W-1:0] finish_hash(input logic [WORD_W-1:0] h);
        logic [WORD_W-1:0] t;
        t = h ^ (h >> SHIFT_R);
        t = t * MUL_K;
        t = t ^ (t >> SHIFT_R);
        return t;
    endfunction

    // fold one accepted key word into the predicted running hash
    task automatic murmur_absorb(input logic [WORD_W-1:0] kw, input logic [NB_W-1:0] nb_in,
                                 input logic first, input logic [LEN_W-1:0] klen);
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] low_mask;
        int                nb;
        h  = model_hash;
        nb = (nb_in > 8) ? 8 : int'(nb_in);
        if (first)
            h = model_seed ^ (WORD_W'(klen) * MUL_K);
        if (nb == 8) begin
            h = (h ^ scramble_word(kw)) * MUL_K;
        end else if (nb != 0) begin
            low_mask = (64'd1 << (8 * nb)) - 64'd1;
            h = (h ^ (kw & low_mask)) * MUL_K;
        end
        model_hash = h;
    endtask

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] wanted);
        $display("%0t mismatch: %s got %h wanted %h", $realtime, what, got, wanted);
        mismatch_count++;
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // send one key word, called at a falling edge, returns at a falling edge with valid still up
    task automatic send_word(input logic [WORD_W-1:0] kw, input logic [NB_W-1:0] nb,
                             input logic first, input logic last, input logic [LEN_W-1:0] klen);
        while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - WORD_W - NB_W - LEN_W){1'b0}}, klen, nb, kw};
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        murmur_absorb(kw, nb, first, klen);
        if (last)
            pending_hashes.push_back(finish_hash(model_hash));
        words_sent++;
        @(negedge i_clk);
    endtask

    // drop valid, wait for every pending hash, then let the core settle
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (pending_hashes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // seed write, core must be idle
    task automatic write_seed(input logic [WORD_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        model_seed = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // one key: full words then a last word with tail_nb bytes
    task automatic send_key(input int n_words, input logic [LEN_W-1:0] klen, input int tail_nb);
        logic [NB_W-1:0] nb;
        for (int i = 0; i < n_words; i++) begin
            if (i == n_words - 1)
                nb = NB_W'(tail_nb);
            else if ($urandom_range(19) == 0)
                nb = NB_W'($urandom_range(15, 9));
            else
                nb = NB_W'(8);
            send_word(rand_word(), nb, i == 0, i == n_words - 1,
                      (i == 0) ? klen : LEN_W'($urandom));
        end
    endtask

    // random key of mostly small size, length field usually consistent
    task automatic send_random_key();
        int              n_words;
        int              tail_nb;
        logic [LEN_W-1:0] klen;
        n_words = ($urandom_range(19) == 0) ? $urandom_range(40, 7) : $urandom_range(6, 1);
        tail_nb = $urandom_range(8);
        if ($urandom_range(9) < 7)
            klen = LEN_W'((n_words - 1) * 8 + tail_nb);
        else
            klen = LEN_W'($urandom);
        send_key(n_words, klen, tail_nb);
    endtask

    // noise word with every field random
    task automatic send_noise_word();
        send_word(rand_word(), NB_W'($urandom), 1'($urandom), 1'($urandom), LEN_W'($urandom));
    endtask

    // extremes and each special case
    task automatic test_directed();
        // missing first right after reset continues from a zero hash
        send_word(64'h0123456789abcdef, 4'd8, 1'b0, 1'b1, 16'd0);
        // empty key
        send_word(64'hffffffffffffffff, 4'd0, 1'b1, 1'b1, 16'd0);
        send_word('1, 4'd8, 1'b1, 1'b1, 16'hffff);
        send_word('0, 4'd8, 1'b1, 1'b1, 16'd8);
        // one-word keys with each tail size
        for (int nb = 1; nb < 8; nb++)
            send_word('1, NB_W'(nb), 1'b1, 1'b1, LEN_W'(nb));
        // oversized byte counts act as full words
        send_word(64'h8000000000000001, 4'd9, 1'b1, 1'b0, 16'd16);
        send_word(64'h7ffffffffffffffe, 4'd15, 1'b0, 1'b1, 16'hffff);
        // tail before last, then the key goes on
        send_word(64'h00000000deadbeef, 4'd3, 1'b1, 1'b0, 16'd19);
        send_word(64'hfedcba9876543210, 4'd8, 1'b0, 1'b0, 16'd0);
        send_word(64'haaaaaaaa55555555, 4'd5, 1'b0, 1'b1, 16'd0);
        // missing first after a finished key, empty word mid-key
        send_word(64'h5555555555555555, 4'd0, 1'b0, 1'b0, 16'd0);
        send_word(64'h0f0f0f0f0f0f0f0f, 4'd8, 1'b0, 1'b1, 16'd0);
        wait_results_done();
    endtask

    // seed extremes, each with a few keys
    task automatic test_seed_sweep();
        logic [WORD_W-1:0] seeds[4];
        seeds = '{64'hffffffffffffffff, 64'h8000000000000000, 64'h0000000000000001, '0};
        foreach (seeds[i]) begin
            write_seed(seeds[i]);
            send_key(1, 16'd0, 0);
            send_key(2, 16'hffff, 8);
            send_key(3, 16'd21, 5);
            wait_results_done();
        end
    endtask

    // back-to-back words with the receiver always ready
    task automatic test_back_to_back();
        no_gaps = 1'b1;
        write_seed({$urandom, $urandom});
        for (int i = 0; i < 40; i++)
            send_random_key();
        wait_results_done();
        no_gaps = 1'b0;
    endtask

    // random keys with noise, new seed each phase after a full drain
    task automatic test_random_keys();
        int goal;
        goal = words_sent + RANDOM_WORDS;
        while (words_sent < goal) begin
            write_seed(($urandom_range(4) == 0) ? '1 : {$urandom, $urandom});
            for (int i = 0; i < 80 && words_sent < goal; i++) begin
                if ($urandom_range(99) < 15)
                    send_noise_word();
                else
                    send_random_key();
            end
            wait_results_done();
        end
    endtask

    // result sink readiness
    always @(negedge i_clk)
        m_axis_tready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);

    // check each hash against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_hashes.size() == 0) begin
                report_mismatch("hash with nothing pending", m_axis_tdata, '0);
            end else begin
                want_hash = pending_hashes.pop_front();
                if (m_axis_tdata !== want_hash)
                    report_mismatch("hash_value", m_axis_tdata, want_hash);
            end
        end
    end

    // watchdog on cycles without any input, output or seed write handshake
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("murmur64a_key_hash_core_test: FAIL");
            $finish;
        end
    end

    // reset, tests, verdict
    initial begin
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_seed_sweep();
        test_back_to_back();
        test_random_keys();
        wait_results_done();
        if (mismatch_count == 0)
            $display("murmur64a_key_hash_core_test: PASS");
        else
            $display("murmur64a_key_hash_core_test: FAIL");
        $finish;
    end

endmodule
